>>> sv/cdq_pkg.sv
`timescale 1ns / 1ps
// cdq_pkg: request and status codes, memory control struct and defaults
// for the circular deque. No dependencies.
package cdq_pkg;

    localparam int DEPTH_DEFAULT = 8;

    localparam logic [1:0] REQ_PUSH_BACK  = 2'd0;
    localparam logic [1:0] REQ_PUSH_FRONT = 2'd1;
    localparam logic [1:0] REQ_POP_FRONT  = 2'd2;
    localparam logic [1:0] REQ_POP_BACK   = 2'd3;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } cdq_mem_ctl_t;

endpackage

>>> sv/cdq_ram.sv
`timescale 1ns / 1ps
// cdq_ram: single-port ring store with a registered read.
// Depends on cdq_pkg.
module cdq_ram
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic               clk,
    input  cdq_mem_ctl_t       mem_ctl,
    input  logic [IW-1:0]      mem_addr,
    input  logic signed [31:0] mem_wdata,
    output logic signed [31:0] mem_rdata
);

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_ctl.wr_en)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_ctl.rd_en)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    assign mem_rdata = rdata_reg;

endmodule

>>> sv/cdq_ctrl.sv
`timescale 1ns / 1ps
// cdq_ctrl: head/tail/count registers, request decode, memory access
// issue and result register. Depends on cdq_pkg.
module cdq_ctrl
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         req_type,
    input  logic signed [31:0] push_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic signed [31:0] popped_value,
    output logic [3:0]         occupancy,
    output cdq_mem_ctl_t       mem_ctl,
    output logic [IW-1:0]      mem_addr,
    output logic signed [31:0] mem_wdata,
    input  logic signed [31:0] mem_rdata
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RESP = 1'b1;

    logic          state_reg;
    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;

    logic [1:0]    pend_status_reg;
    logic          pend_pop_reg;
    logic [3:0]    pend_occ_reg;

    logic               out_valid_reg;
    logic [1:0]         out_status_reg;
    logic signed [31:0] out_value_reg;
    logic [3:0]         out_occ_reg;

    logic          out_free;
    logic          in_fire;
    logic          resp_fire;
    logic          full;
    logic          empty;
    logic [IW-1:0] head_inc, head_dec, tail_inc, tail_dec;
    logic          wr_req, rd_req, pop_ok;
    logic [1:0]    req_status;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) || out_free;
    assign in_fire   = in_valid && in_ready;
    assign resp_fire = (state_reg == S_RESP) && out_free;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    assign head_inc = (head_reg == IW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? IW'(DEPTH - 1) : head_reg - 1'b1;
    assign tail_inc = (tail_reg == IW'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? IW'(DEPTH - 1) : tail_reg - 1'b1;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        mem_addr   = tail_reg;
        wr_req     = 1'b0;
        rd_req     = 1'b0;
        pop_ok     = 1'b0;
        req_status = ST_DONE;
        case (req_type)
            REQ_PUSH_BACK:
            begin
                if (full)
                begin
                    req_status = ST_OVERFLOW;
                end
                else
                begin
                    wr_req     = 1'b1;
                    mem_addr   = tail_reg;
                    tail_next  = tail_inc;
                    count_next = count_reg + 1'b1;
                end
            end
            REQ_PUSH_FRONT:
            begin
                if (full)
                begin
                    req_status = ST_OVERFLOW;
                end
                else
                begin
                    wr_req     = 1'b1;
                    mem_addr   = head_dec;
                    head_next  = head_dec;
                    count_next = count_reg + 1'b1;
                end
            end
            REQ_POP_FRONT:
            begin
                if (empty)
                begin
                    req_status = ST_UNDERFLOW;
                end
                else
                begin
                    rd_req     = 1'b1;
                    pop_ok     = 1'b1;
                    mem_addr   = head_reg;
                    head_next  = head_inc;
                    count_next = count_reg - 1'b1;
                end
            end
            REQ_POP_BACK:
            begin
                if (empty)
                begin
                    req_status = ST_UNDERFLOW;
                end
                else
                begin
                    rd_req     = 1'b1;
                    pop_ok     = 1'b1;
                    mem_addr   = tail_dec;
                    tail_next  = tail_dec;
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                req_status = ST_DONE;
            end
        endcase
    end

    assign mem_ctl.wr_en = in_fire && wr_req;
    assign mem_ctl.rd_en = in_fire && rd_req;
    assign mem_wdata     = push_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                state_reg <= S_RESP;
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
            end
            else if (resp_fire)
            begin
                state_reg <= S_IDLE;
            end

            if (resp_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pend_status_reg <= req_status;
            pend_pop_reg    <= pop_ok;
            pend_occ_reg    <= 4'(count_next);
        end
        if (resp_fire)
        begin
            out_status_reg <= pend_status_reg;
            out_value_reg  <= pend_pop_reg ? mem_rdata : 32'sd0;
            out_occ_reg    <= pend_occ_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign popped_value = out_value_reg;
    assign occupancy    = out_occ_reg;

endmodule

>>> sv/circular_deque_core.sv
`timescale 1ns / 1ps
// circular_deque_core: double-ended queue in a ring memory of DEPTH words.
// Result path: the memory read register loads at the accepting edge, and the
// result register loads once the result side is free; a stall can come between.
// Throughput: one transaction per cycle while the result side keeps up;
// a stalled result register holds off the next request once one is pending.
// Reset: pointers and count clear at once; the ring store is not cleared.
// Depends on cdq_pkg, cdq_ctrl, cdq_ram.
module circular_deque_core
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         req_type,
    input  logic signed [31:0] push_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic signed [31:0] popped_value,
    output logic [3:0]         occupancy
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cdq_mem_ctl_t       mem_ctl;
    logic [IW-1:0]      mem_addr;
    logic signed [31:0] mem_wdata;
    logic signed [31:0] mem_rdata;

    cdq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .push_value   (push_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .popped_value (popped_value),
        .occupancy    (occupancy),
        .mem_ctl      (mem_ctl),
        .mem_addr     (mem_addr),
        .mem_wdata    (mem_wdata),
        .mem_rdata    (mem_rdata)
    );

    cdq_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .clk       (clk),
        .mem_ctl   (mem_ctl),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

`ifndef ASSERT_OFF
    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_UNDERFLOW) |->
            (occupancy == 4'd0 && popped_value == 32'sd0))
        else $error("underflow result with non-empty occupancy or data");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_OVERFLOW) |->
            (occupancy == 4'(DEPTH) && popped_value == 32'sd0))
        else $error("overflow result without full occupancy");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(status) && $stable(popped_value) && $stable(occupancy)))
        else $error("result transaction changed while stalled");
`endif

endmodule
